@@ rtl/mscg_pkg.sv @@
package mscg_pkg;

   localparam int DEFAULT_MAX_STOPS   = 6;
   localparam int DEFAULT_LENGTH_BITS = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   // Register map of the configuration port. Stop s lives at REG_STOP_0 + s.
   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_COUNT      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRADIENT_LENGTH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_0          = 3'd2;

   localparam logic [2:0] STOP_COUNT_RESET = 3'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic start_qr;
      logic load_lp;
      logic seg_first;
      logic seg_next;
      logic step;
      logic start_pdiv;
      logic fetch;
      logic start_cdiv;
      logic start_kdiv;
      logic ch_zero;
      logic ch_next;
      logic emit;
   } mscg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic dirty;
      logic pos_zero;
      logic trk;
      logic seg_end;
      logic k_zero;
      logic div_done;
      logic last_ch;
      logic out_free;
   } mscg_sts_type;

endpackage

@@ rtl/mscg_div.sv @@
module mscg_div #(
   parameter int LENGTH_BITS = mscg_pkg::DEFAULT_LENGTH_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [LENGTH_BITS+8:0] dividend,
   input  logic        [LENGTH_BITS-1:0] divisor,
   output logic                          done,
   output logic signed [LENGTH_BITS+8:0] quotient,
   output logic        [LENGTH_BITS-1:0] remainder
);
   import mscg_pkg::*;

   localparam int LB = LENGTH_BITS;
   localparam int DW = LENGTH_BITS + 8;
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [LB-1:0] rem_ff, rem_in;
   logic [LB-1:0] dvs_ff, dvs_in;

   logic [LB:0]   trial;
   logic [LB:0]   diff;
   logic          fits;
   logic [DW:0]   abs_full;
   logic [DW:0]   qm;
   logic          rem_nz;

   // Restoring division on the magnitude, one quotient bit a cycle, then a
   // floor correction for a negative dividend.
   always_comb begin
      trial    = {rem_ff, acc_ff[DW-1]};
      diff     = trial - {1'b0, dvs_ff};
      fits     = trial >= {1'b0, dvs_ff};
      abs_full = dividend[DW] ? (~dividend + (DW+1)'(1)) : dividend;
      qm       = {1'b0, acc_ff};
      rem_nz   = rem_ff != '0;
      done     = busy_ff && (cnt_ff == '0);

      if (neg_ff) begin
         quotient  = $signed(~qm + {{DW{1'b0}}, ~rem_nz});
         remainder = rem_nz ? (dvs_ff - rem_ff) : '0;
      end else begin
         quotient  = $signed(qm);
         remainder = rem_ff;
      end

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         neg_in  = dividend[DW];
         acc_in  = abs_full[DW-1:0];
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff && (cnt_ff != '0)) begin
         acc_in = {acc_ff[DW-2:0], fits};
         rem_in = fits ? diff[LB-1:0] : trial[LB-1:0];
         cnt_in = cnt_ff - CW'(1);
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

@@ rtl/mscg_dp.sv @@
module mscg_dp #(
   parameter int MAX_STOPS   = mscg_pkg::DEFAULT_MAX_STOPS,
   parameter int LENGTH_BITS = mscg_pkg::DEFAULT_LENGTH_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mscg_pkg::mscg_cmd_type               cmd,
   output mscg_pkg::mscg_sts_type               sts,
   input  logic                                 req_restart,
   input  logic                                 csr_write_en,
   input  logic [mscg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mscg_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [7:0]                           rsp_red,
   output logic [7:0]                           rsp_green,
   output logic [7:0]                           rsp_blue,
   output logic [15:0]                          rsp_position,
   output logic                                 rsp_final_res
);
   import mscg_pkg::*;

   localparam int LB  = LENGTH_BITS;
   localparam int DW  = LENGTH_BITS + 8;
   localparam int NW  = $clog2(MAX_STOPS + 1);
   localparam int SIW = $clog2(MAX_STOPS);

   localparam logic [1:0] OP_QR  = 2'd0;
   localparam logic [1:0] OP_POS = 2'd1;
   localparam logic [1:0] OP_CD  = 2'd2;
   localparam logic [1:0] OP_KD  = 2'd3;

   // Configuration.
   logic [2:0]           stop_count_ff, stop_count_in;
   logic [LB-1:0]        len_ff, len_in;
   logic [23:0]          stop_mem [MAX_STOPS];
   logic [MAX_STOPS-1:0] stop_vld_ff, stop_vld_in;
   logic [23:0]          rd_a_ff, rd_b_ff;

   // Walk state.
   logic [LB-1:0]  pos_ff, pos_in;
   logic           dirty_ff, dirty_in;
   logic           trk_ff, trk_in;
   logic [LB-1:0]  q_ff, q_in;
   logic [NW-1:0]  r_ff, r_in;
   logic [LB-1:0]  lp_ff, lp_in;
   logic [SIW-1:0] seg_ff, seg_in;
   logic [LB-1:0]  k_ff, k_in;
   logic [LB-1:0]  m_ff, m_in;
   logic [1:0]     ch_ff, ch_in;
   logic [1:0]     op_ff, op_in;

   // Per-channel quotient/remainder stepping.
   logic signed [8:0] cq_ff [3];
   logic signed [8:0] cq_in [3];
   logic signed [8:0] sq_ff [3];
   logic signed [8:0] sq_in [3];
   logic [LB-1:0]     ce_ff [3];
   logic [LB-1:0]     ce_in [3];
   logic [LB-1:0]     sr_ff [3];
   logic [LB-1:0]     sr_in [3];
   logic [LB:0]       e_sum [3];
   logic              carry [3];

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [15:0] position_ff, position_in;
   logic        final_ff, final_in;

   logic [NW-1:0]        n_w;
   logic [NW-1:0]        segs;
   logic                 empty;
   logic [LB:0]          q_inc;
   logic [LB-1:0]        m_first;
   logic [LB-1:0]        m_next;
   logic                 seg_end;
   logic                 short_part;
   logic [NW+LB:0]       lp_full;
   logic [SIW-1:0]       seg_p1;
   logic [7:0]           u_sel, v_sel;
   logic signed [8:0]    d_sel;
   logic signed [LB+9:0] kd_full;
   logic [LB+15:0]       len_wide;
   logic [LB+15:0]       pos_wide;
   logic [2:0]           stop_wr_off;
   logic                 stop_wr_ok;
   logic [SIW-1:0]       stop_wr_idx;
   logic                 stop_wr;
   logic [LB:0]          pos_inc;

   logic                 div_start;
   logic signed [DW:0]   div_dividend;
   logic [LB-1:0]        div_divisor;
   logic                 div_done;
   logic signed [DW:0]   div_quot;
   logic [LB-1:0]        div_rem;

   mscg_div #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      n_w     = (int'(stop_count_ff) > MAX_STOPS) ? NW'(MAX_STOPS) : NW'(stop_count_ff);
      segs    = n_w - NW'(1);
      empty   = (len_ff == '0) || (n_w < NW'(2));
      q_inc   = {1'b0, q_ff} + (LB+1)'(1);
      m_first = (r_ff != '0) ? q_inc[LB-1:0] : q_ff;
      m_next  = ((int'(seg_ff) + 1) < int'(r_ff)) ? q_inc[LB-1:0] : q_ff;
      seg_end = ({1'b0, k_ff} + (LB+1)'(1)) == {1'b0, m_ff};
      short_part = pos_ff >= lp_ff;
      lp_full = (NW+LB+1)'(r_ff) * (NW+LB+1)'(q_inc);
      seg_p1  = seg_ff + SIW'(1);
      pos_inc = {1'b0, pos_ff} + (LB+1)'(1);

      case (ch_ff)
         2'd0: begin
            u_sel = rd_a_ff[23:16];
            v_sel = rd_b_ff[23:16];
         end
         2'd1: begin
            u_sel = rd_a_ff[15:8];
            v_sel = rd_b_ff[15:8];
         end
         default: begin
            u_sel = rd_a_ff[7:0];
            v_sel = rd_b_ff[7:0];
         end
      endcase
      d_sel   = $signed({1'b0, v_sel}) - $signed({1'b0, u_sel});
      kd_full = $signed({1'b0, k_ff}) * d_sel;

      len_wide    = {{LB{1'b0}}, csr_data[15:0]};
      pos_wide    = {16'b0, pos_ff};
      stop_wr_off = csr_index - REG_STOP_0;
      stop_wr_ok  = int'(stop_wr_off) < MAX_STOPS;
      stop_wr_idx = SIW'(stop_wr_off);
      stop_wr     = csr_write_en && (csr_index >= REG_STOP_0) && stop_wr_ok;

      for (int c = 0; c < 3; c++) begin
         e_sum[c] = {1'b0, ce_ff[c]} + {1'b0, sr_ff[c]};
         carry[c] = e_sum[c] >= {1'b0, m_ff};
      end
   end

   // Operand selection for the shared divider.
   always_comb begin
      div_start    = cmd.start_qr || cmd.start_pdiv || cmd.start_cdiv || cmd.start_kdiv;
      div_dividend = $signed({9'b0, len_ff});
      div_divisor  = LB'(segs);
      op_in        = op_ff;
      if (cmd.start_qr) begin
         op_in = OP_QR;
      end else if (cmd.start_pdiv) begin
         op_in = OP_POS;
         if (short_part) begin
            div_dividend = $signed({9'b0, pos_ff - lp_ff});
            div_divisor  = q_ff;
         end else begin
            div_dividend = $signed({9'b0, pos_ff});
            div_divisor  = q_inc[LB-1:0];
         end
      end else if (cmd.start_cdiv) begin
         op_in        = OP_CD;
         div_dividend = $signed({{LB{d_sel[8]}}, d_sel});
         div_divisor  = m_ff;
      end else if (cmd.start_kdiv) begin
         op_in        = OP_KD;
         div_dividend = kd_full[DW:0];
         div_divisor  = m_ff;
      end
   end

   always_comb begin
      stop_count_in = stop_count_ff;
      len_in        = len_ff;
      stop_vld_in   = stop_vld_ff;
      pos_in        = pos_ff;
      dirty_in      = dirty_ff;
      trk_in        = trk_ff;
      q_in          = q_ff;
      r_in          = r_ff;
      lp_in         = lp_ff;
      seg_in        = seg_ff;
      k_in          = k_ff;
      m_in          = m_ff;
      ch_in         = ch_ff;
      for (int c = 0; c < 3; c++) begin
         cq_in[c] = cq_ff[c];
         sq_in[c] = sq_ff[c];
         ce_in[c] = ce_ff[c];
         sr_in[c] = sr_ff[c];
      end
      rsp_valid_in = rsp_valid_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      position_in  = position_ff;
      final_in     = final_ff;

      if (csr_write_en) begin
         dirty_in = 1'b1;
         trk_in   = 1'b0;
         case (csr_index)
            REG_STOP_COUNT:      stop_count_in = csr_data[2:0];
            REG_GRADIENT_LENGTH: len_in = len_wide[LB-1:0];
            default: begin
               if (stop_wr) begin
                  stop_vld_in[stop_wr_idx] = 1'b1;
               end
            end
         endcase
      end

      if (cmd.take) begin
         if (empty || req_restart || (pos_ff >= len_ff)) begin
            pos_in = '0;
         end
      end

      if (div_done) begin
         case (op_ff)
            OP_QR: begin
               q_in     = div_quot[LB-1:0];
               r_in     = NW'(div_rem);
               dirty_in = 1'b0;
               trk_in   = 1'b0;
            end
            OP_POS: begin
               seg_in = seg_ff + div_quot[SIW-1:0];
               k_in   = div_rem;
            end
            OP_CD: begin
               sq_in[ch_ff] = div_quot[8:0];
               sr_in[ch_ff] = div_rem;
            end
            default: begin
               cq_in[ch_ff] = div_quot[8:0];
               ce_in[ch_ff] = div_rem;
            end
         endcase
      end

      if (cmd.load_lp) begin
         lp_in = lp_full[LB-1:0];
      end

      if (cmd.seg_first) begin
         seg_in = '0;
         k_in   = '0;
         m_in   = m_first;
      end

      if (cmd.seg_next) begin
         seg_in = seg_p1;
         k_in   = '0;
         m_in   = m_next;
      end

      if (cmd.start_pdiv) begin
         if (short_part) begin
            seg_in = SIW'(r_ff);
            m_in   = q_ff;
         end else begin
            seg_in = '0;
            m_in   = q_inc[LB-1:0];
         end
      end

      if (cmd.step) begin
         k_in = k_ff + LB'(1);
         for (int c = 0; c < 3; c++) begin
            ce_in[c] = carry[c] ? (e_sum[c][LB-1:0] - m_ff) : e_sum[c][LB-1:0];
            cq_in[c] = cq_ff[c] + sq_ff[c] + $signed({8'b0, carry[c]});
         end
      end

      if (cmd.fetch) begin
         ch_in = '0;
      end
      if (cmd.ch_next) begin
         ch_in = ch_ff + 2'd1;
      end
      if (cmd.ch_zero) begin
         cq_in[ch_ff] = '0;
         ce_in[ch_ff] = '0;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         red_in       = rd_a_ff[23:16] + cq_ff[0][7:0];
         green_in     = rd_a_ff[15:8] + cq_ff[1][7:0];
         blue_in      = rd_a_ff[7:0] + cq_ff[2][7:0];
         position_in  = pos_wide[15:0];
         final_in     = pos_ff == (len_ff - LB'(1));
         pos_in       = (pos_inc >= {1'b0, len_ff}) ? '0 : pos_inc[LB-1:0];
         trk_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= STOP_COUNT_RESET;
         len_ff        <= '0;
         stop_vld_ff   <= '0;
         pos_ff        <= '0;
         dirty_ff      <= 1'b1;
         trk_ff        <= 1'b0;
         ch_ff         <= '0;
         op_ff         <= OP_QR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         stop_count_ff <= stop_count_in;
         len_ff        <= len_in;
         stop_vld_ff   <= stop_vld_in;
         pos_ff        <= pos_in;
         dirty_ff      <= dirty_in;
         trk_ff        <= trk_in;
         ch_ff         <= ch_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      lp_ff  <= lp_in;
      seg_ff <= seg_in;
      k_ff   <= k_in;
      m_ff   <= m_in;
      for (int c = 0; c < 3; c++) begin
         cq_ff[c] <= cq_in[c];
         sq_ff[c] <= sq_in[c];
         ce_ff[c] <= ce_in[c];
         sr_ff[c] <= sr_in[c];
      end
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      position_ff <= position_in;
      final_ff    <= final_in;
   end

   // Stop colors: one write port from the configuration side, two registered
   // reads for the stops that bound the current segment. An entry that was
   // never written reads as black.
   always_ff @(posedge clock) begin
      if (stop_wr) begin
         stop_mem[stop_wr_idx] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_a_ff <= stop_vld_ff[seg_ff] ? stop_mem[seg_ff] : '0;
         rd_b_ff <= stop_vld_ff[seg_p1] ? stop_mem[seg_p1] : '0;
      end
   end

   always_comb begin
      sts.empty    = empty;
      sts.dirty    = dirty_ff;
      sts.pos_zero = pos_ff == '0;
      sts.trk      = trk_ff;
      sts.seg_end  = seg_end;
      sts.k_zero   = k_ff == '0;
      sts.div_done = div_done;
      sts.last_ch  = ch_ff == 2'd2;
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_position  = position_ff;
   assign rsp_final_res = final_ff;

endmodule

@@ rtl/mscg_ctrl.sv @@
module mscg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mscg_pkg::mscg_sts_type sts,
   output mscg_pkg::mscg_cmd_type cmd
);
   import mscg_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_QRW   = 4'd1;
   localparam logic [3:0] S_LP    = 4'd2;
   localparam logic [3:0] S_LOC   = 4'd3;
   localparam logic [3:0] S_PWAIT = 4'd4;
   localparam logic [3:0] S_FETCH = 4'd5;
   localparam logic [3:0] S_CHAN  = 4'd6;
   localparam logic [3:0] S_CW1   = 4'd7;
   localparam logic [3:0] S_CW2   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = state_ff != S_IDLE;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (!sts.empty) begin
                  if (sts.dirty) begin
                     cmd.start_qr = 1'b1;
                     state_in     = S_QRW;
                  end else begin
                     state_in = S_LOC;
                  end
               end
            end
         end
         S_QRW: begin
            if (sts.div_done) begin
               state_in = S_LP;
            end
         end
         S_LP: begin
            cmd.load_lp = 1'b1;
            state_in    = S_LOC;
         end
         S_LOC: begin
            if (sts.pos_zero) begin
               cmd.seg_first = 1'b1;
               state_in      = S_FETCH;
            end else if (sts.trk && !sts.seg_end) begin
               cmd.step = 1'b1;
               state_in = S_OUT;
            end else if (sts.trk) begin
               cmd.seg_next = 1'b1;
               state_in     = S_FETCH;
            end else begin
               cmd.start_pdiv = 1'b1;
               state_in       = S_PWAIT;
            end
         end
         S_PWAIT: begin
            if (sts.div_done) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_CHAN;
         end
         S_CHAN: begin
            cmd.start_cdiv = 1'b1;
            state_in       = S_CW1;
         end
         S_CW1: begin
            if (sts.div_done) begin
               if (sts.k_zero) begin
                  cmd.ch_zero = 1'b1;
                  if (sts.last_ch) begin
                     state_in = S_OUT;
                  end else begin
                     cmd.ch_next = 1'b1;
                     state_in    = S_CHAN;
                  end
               end else begin
                  cmd.start_kdiv = 1'b1;
                  state_in       = S_CW2;
               end
            end
         end
         S_CW2: begin
            if (sts.div_done) begin
               if (sts.last_ch) begin
                  state_in = S_OUT;
               end else begin
                  cmd.ch_next = 1'b1;
                  state_in    = S_CHAN;
               end
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/multi_stop_color_gradient_core.sv @@
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_restart
// rsp       out        rsp_valid/rsp_stall  rsp_red, rsp_green, rsp_blue, rsp_position,
//                                           rsp_final_res
// csr       in         csr_write_en         csr_index, csr_data
//
// A color inside a segment is made in order: accept, one quotient/remainder step, and the
// load of the result register.
// The first color of a segment runs three floor divisions (one per channel) through the
// shared bit-serial divider.
// After a configuration write, the first request adds one divider pass for the segment
// split, and if the walk is resumed mid-segment, one pass to find the position and one
// pass per channel for the scaled offset.
// Reset is synchronous and returns the control, configuration and position registers to their defaults.
// A stalled result stays in the output register while the next request is accepted
// and computed; that request then waits for the result register to free up.
module multi_stop_color_gradient_core #(
   parameter int MAX_STOPS   = mscg_pkg::DEFAULT_MAX_STOPS,
   parameter int LENGTH_BITS = mscg_pkg::DEFAULT_LENGTH_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_red,
   output logic [7:0]                          rsp_green,
   output logic [7:0]                          rsp_blue,
   output logic [15:0]                         rsp_position,
   output logic                                rsp_final_res,
   input  logic                                csr_write_en,
   input  logic [mscg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mscg_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import mscg_pkg::*;

   // The controller only sequences; every register of the walk lives in the
   // datapath. The two talk through one command struct and one status struct.
   mscg_cmd_type cmd;
   mscg_sts_type sts;

   // The sequencer decides, per transaction, whether the next color is a simple
   // step inside the current segment, the start of a new segment, or a fresh
   // entry into the walk after the configuration changed.
   mscg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, the stop memory, the position and
   // segment trackers, the per-channel quotient/remainder steppers, the shared
   // divider and the result register.
   mscg_dp #(
      .MAX_STOPS   (MAX_STOPS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_restart   (req_restart),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_position  (rsp_position),
      .rsp_final_res (rsp_final_res)
   );

   // A new result is never written over one that is still waiting.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result register overwritten while its transaction is pending");

   // The divider is shared, so only one division may be launched at a time.
   a_one_div: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start_qr, cmd.start_pdiv, cmd.start_cdiv, cmd.start_kdiv}))
      else $error("more than one division launched in a cycle");

   // Loading the result register always presents it on the next cycle.
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result loaded but not presented");

   // A request that produces a color keeps the input stalled while it is computed.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !sts.empty) |=> req_stall)
      else $error("new request accepted while a color is being computed");

endmodule
